// ===== rtl/core/gre_pkg.sv =====
// ----------------------------------------------------------------------------
// gre_pkg
// Shared types and constants for the graph reachability engine.
// ----------------------------------------------------------------------------
package gre_pkg;

  localparam int unsigned VW = 6;   // vertex index width
  localparam int unsigned RW = 64;  // adjacency row / mask width
  localparam int unsigned CW = 7;   // vertex_count width

  localparam logic [1:0] KIND_ADD_EDGE = 2'd0;
  localparam logic [1:0] KIND_PAIR_Q   = 2'd1;
  localparam logic [1:0] KIND_VERTEX_Q = 2'd2;

  // controller -> search unit
  typedef struct packed {
    logic          init;   // load start vertex
    logic          run;    // expand frontier / absorb read data
    logic [VW-1:0] start;
    logic [RW-1:0] act;    // active vertex mask
  } srch_cmd_t;

  // search unit -> controller
  typedef struct packed {
    logic          rd_en;
    logic [VW-1:0] rd_addr;
    logic          done;
  } srch_sts_t;

endpackage

// ===== rtl/core/gre_adj_mem.sv =====
// ----------------------------------------------------------------------------
// gre_adj_mem
// Adjacency row memory, one write and one read port, registered read.
// Per-row valid bits cleared at reset; an unwritten row reads as zero.
// ----------------------------------------------------------------------------
module gre_adj_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   rd_en,
  input  logic [AW-1:0]          rd_addr,
  output logic [gre_pkg::RW-1:0] rd_data,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  logic [gre_pkg::RW-1:0] wr_data
);

  logic [gre_pkg::RW-1:0] mem [DEPTH];
  logic [DEPTH-1:0]       row_vld_r;
  logic [gre_pkg::RW-1:0] rd_data_r;
  logic                   rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= row_vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (wr_en) begin
      row_vld_r[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

// ===== rtl/core/gre_search.sv =====
// ----------------------------------------------------------------------------
// gre_search
// Visited / frontier sets for the component search. Issues one row read a
// cycle for the lowest vertex of a non-empty frontier; returning rows fold in.
// ----------------------------------------------------------------------------
module gre_search (
  input  logic                   clk,
  input  logic                   rst_n,
  input  gre_pkg::srch_cmd_t     cmd,
  input  logic [gre_pkg::RW-1:0] rd_data,
  output gre_pkg::srch_sts_t     sts,
  output logic [gre_pkg::RW-1:0] visited,
  output logic [gre_pkg::RW-1:0] reach,
  output logic [gre_pkg::RW-1:0] nbr
);

  logic [gre_pkg::RW-1:0] visited_r, visited_nxt;
  logic [gre_pkg::RW-1:0] frontier_r, frontier_nxt;
  logic [gre_pkg::RW-1:0] reach_r, reach_nxt;
  logic [gre_pkg::RW-1:0] nbr_r, nbr_nxt;
  logic                   pend_r, pend_nxt;
  logic                   first_r, first_nxt;
  logic [gre_pkg::RW-1:0] low_bit;
  logic [gre_pkg::RW-1:0] row_act;
  logic [gre_pkg::RW-1:0] fresh;
  logic [gre_pkg::VW-1:0] pick;
  logic                   issue;

  // isolate lowest set bit, then encode it
  assign low_bit = frontier_r & (~frontier_r + 1'b1);

  always_comb begin
    pick = '0;
    for (int j = 0; j < gre_pkg::RW; j++) begin
      if (low_bit[j]) pick = pick | gre_pkg::VW'(j);
    end
  end

  assign issue   = cmd.run && (frontier_r != '0);
  assign row_act = rd_data & cmd.act;
  assign fresh   = (cmd.run && pend_r) ? (row_act & ~visited_r) : '0;

  always_comb begin
    visited_nxt  = visited_r;
    frontier_nxt = frontier_r;
    reach_nxt    = reach_r;
    nbr_nxt      = nbr_r;
    pend_nxt     = pend_r;
    first_nxt    = first_r;
    if (cmd.init) begin
      visited_nxt  = gre_pkg::RW'(1) << cmd.start;
      frontier_nxt = gre_pkg::RW'(1) << cmd.start;
      reach_nxt    = '0;
      pend_nxt     = 1'b0;
      first_nxt    = 1'b1;
    end else if (cmd.run) begin
      visited_nxt  = visited_r | fresh;
      frontier_nxt = (frontier_r & ~(issue ? low_bit : '0)) | fresh;
      pend_nxt     = issue;
      if (pend_r) begin
        reach_nxt = reach_r | row_act;
        first_nxt = 1'b0;
        if (first_r) nbr_nxt = row_act;  // first row is the start vertex
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frontier_r <= '0;
      pend_r     <= 1'b0;
      first_r    <= 1'b0;
    end else begin
      frontier_r <= frontier_nxt;
      pend_r     <= pend_nxt;
      first_r    <= first_nxt;
    end
  end

  always_ff @(posedge clk) begin
    visited_r <= visited_nxt;
    reach_r   <= reach_nxt;
    nbr_r     <= nbr_nxt;
  end

  assign sts.rd_en   = issue;
  assign sts.rd_addr = pick;
  assign sts.done    = (frontier_r == '0) && !pend_r;
  assign visited     = visited_r;
  assign reach       = reach_r;
  assign nbr         = nbr_r;

endmodule

// ===== rtl/core/graph_reachability_engine_core.sv =====
// ----------------------------------------------------------------------------
// graph_reachability_engine_core
// Undirected graph store with edge insert, pair and vertex connectivity query.
// ----------------------------------------------------------------------------
// One item is in flight at a time; in_stall is high from the transfer until
// the item's result is loaded into the output register. An add-edge does two
// read-modify-writes of the row memory (read row a; write row a while reading
// row b; write row b), while a self-loop or an out-of-range item goes straight
// to the result load. A query seeds a search that reads one row a cycle
// through the single read port of the row memory, except that it stalls each
// time the frontier runs dry while a row read is still on its way back (as on
// a long chain). The result register lets the next item transfer in while a
// result waits on out_stall. The adjacency rows reset to empty through per-row
// valid bits, so no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module graph_reachability_engine_core #(
  parameter int unsigned MAX_VERTICES = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration
  input  logic                   cfg_we,
  input  logic [gre_pkg::CW-1:0] cfg_wdata,
  // input channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             in_kind,
  input  logic [gre_pkg::VW-1:0] in_first_vertex,
  input  logic [gre_pkg::VW-1:0] in_second_vertex,
  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_status,
  output logic                   out_adjacent,
  output logic                   out_reachable,
  output logic [gre_pkg::RW-1:0] out_neighbour_mask,
  output logic [gre_pkg::RW-1:0] out_component_mask
);

  localparam int unsigned AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam logic [gre_pkg::CW-1:0] MAX_CNT = gre_pkg::CW'(MAX_VERTICES);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_E_RDA = 7'b0000010,  // read row a
    ST_E_WRA = 7'b0000100,  // write row a, read row b
    ST_E_WRB = 7'b0001000,  // write row b
    ST_S_INI = 7'b0010000,  // seed search
    ST_S_RUN = 7'b0100000,  // expand frontier
    ST_FIN   = 7'b1000000   // load result register
  } state_t;

  state_t                 state_r, state_nxt;
  logic [gre_pkg::CW-1:0] vcount_r;
  logic [1:0]             kind_r;
  logic [gre_pkg::VW-1:0] va_r, vb_r;
  logic                   err_r;
  logic [gre_pkg::RW-1:0] act_r;

  logic [gre_pkg::CW-1:0] count;
  logic                   in_xfer, out_xfer_ok, in_err;

  // memory port
  logic                   rd_en, wr_en;
  logic [AW-1:0]          rd_addr, wr_addr;
  logic [gre_pkg::RW-1:0] rd_data, wr_data;

  gre_pkg::srch_cmd_t     scmd;
  gre_pkg::srch_sts_t     ssts;
  logic [gre_pkg::RW-1:0] s_visited, s_reach, s_nbr;

  // result register
  logic                   out_valid_r;
  logic                   status_r, adjacent_r, reachable_r;
  logic [gre_pkg::RW-1:0] nbr_mask_r, comp_mask_r;

  // ---- configuration ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= gre_pkg::CW'(64);
    end else if (cfg_we) begin
      vcount_r <= cfg_wdata;
    end
  end

  // active count clamps at the store depth
  assign count = (vcount_r > MAX_CNT) ? MAX_CNT : vcount_r;

  // ---- input check ----
  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    in_err = 1'b0;
    if (in_kind != gre_pkg::KIND_ADD_EDGE && in_kind != gre_pkg::KIND_PAIR_Q &&
        in_kind != gre_pkg::KIND_VERTEX_Q) begin
      in_err = 1'b1;
    end else if ({1'b0, in_first_vertex} >= count) begin
      in_err = 1'b1;
    end else if (in_kind != gre_pkg::KIND_VERTEX_Q && {1'b0, in_second_vertex} >= count) begin
      in_err = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      kind_r <= in_kind;
      va_r   <= in_first_vertex;
      vb_r   <= in_second_vertex;
      err_r  <= in_err;
      act_r  <= (count >= gre_pkg::CW'(64)) ? '1 :
                ((gre_pkg::RW'(1) << count[gre_pkg::VW-1:0]) - 1'b1);
    end
  end

  // ---- controller ----
  assign out_xfer_ok = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_err) state_nxt = ST_FIN;
          else if (in_kind == gre_pkg::KIND_ADD_EDGE) begin
            state_nxt = (in_first_vertex == in_second_vertex) ? ST_FIN : ST_E_RDA;
          end else state_nxt = ST_S_INI;
        end
      end
      ST_E_RDA: state_nxt = ST_E_WRA;
      ST_E_WRA: state_nxt = ST_E_WRB;
      ST_E_WRB: state_nxt = ST_FIN;
      ST_S_INI: state_nxt = ST_S_RUN;
      ST_S_RUN: begin
        if (ssts.done) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_xfer_ok) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---- memory port mux ----
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = va_r[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = va_r[AW-1:0];
    wr_data = rd_data | (gre_pkg::RW'(1) << vb_r);
    unique case (state_r)
      ST_E_RDA: rd_en = 1'b1;
      ST_E_WRA: begin
        wr_en   = 1'b1;
        rd_en   = 1'b1;
        rd_addr = vb_r[AW-1:0];
      end
      ST_E_WRB: begin
        wr_en   = 1'b1;
        wr_addr = vb_r[AW-1:0];
        wr_data = rd_data | (gre_pkg::RW'(1) << va_r);
      end
      ST_S_RUN: begin
        rd_en   = ssts.rd_en;
        rd_addr = ssts.rd_addr[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  gre_adj_mem #(
    .DEPTH (MAX_VERTICES),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // ---- search unit ----
  assign scmd.init  = (state_r == ST_S_INI);
  assign scmd.run   = (state_r == ST_S_RUN);
  assign scmd.start = va_r;
  assign scmd.act   = act_r;

  gre_search u_search (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (scmd),
    .rd_data (rd_data),
    .sts     (ssts),
    .visited (s_visited),
    .reach   (s_reach),
    .nbr     (s_nbr)
  );

  // ---- result register ----
  // fields outside the item's kind, and all but status on error, are zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_FIN && out_xfer_ok) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FIN && out_xfer_ok) begin
      status_r    <= err_r;
      adjacent_r  <= !err_r && kind_r == gre_pkg::KIND_PAIR_Q && va_r != vb_r && s_nbr[vb_r];
      reachable_r <= !err_r && kind_r == gre_pkg::KIND_PAIR_Q && s_reach[vb_r];
      nbr_mask_r  <= (!err_r && kind_r == gre_pkg::KIND_VERTEX_Q) ? s_nbr : '0;
      comp_mask_r <= (!err_r && kind_r == gre_pkg::KIND_VERTEX_Q) ? s_visited : '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_adjacent       = adjacent_r;
  assign out_reachable      = reachable_r;
  assign out_neighbour_mask = nbr_mask_r;
  assign out_component_mask = comp_mask_r;

endmodule

// ===== rtl/core/gre_checker.sv =====
// ----------------------------------------------------------------------------
// gre_checker
// Port-level checks for graph_reachability_engine_core, bound to the top.
// ----------------------------------------------------------------------------
module gre_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic                   out_status,
  input logic                   out_adjacent,
  input logic                   out_reachable,
  input logic [gre_pkg::RW-1:0] out_neighbour_mask,
  input logic [gre_pkg::RW-1:0] out_component_mask
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_adjacent) && $stable(out_reachable) &&
      $stable(out_neighbour_mask) && $stable(out_component_mask))
    else $error("result changed while stalled");

  // one item at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in flight");

  // error results carry nothing else
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> !out_adjacent && !out_reachable &&
      out_neighbour_mask == '0 && out_component_mask == '0)
    else $error("error result with payload");

  // an edge is a walk
  a_adj_reach: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_adjacent |-> out_reachable)
    else $error("adjacent but not reachable");

  // neighbours lie in the component
  a_nbr_comp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_neighbour_mask & ~out_component_mask) == '0)
    else $error("neighbour outside component");

endmodule

bind graph_reachability_engine_core gre_checker u_gre_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_status         (out_status),
  .out_adjacent       (out_adjacent),
  .out_reachable      (out_reachable),
  .out_neighbour_mask (out_neighbour_mask),
  .out_component_mask (out_component_mask)
);
